/* rtl/bwct_pkg.sv */
// Package for the buried-water cylinder test: codes, widths and register constants.
`default_nettype none

package bwct_pkg;

   // Item kinds on the request channel
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_ATOM  = 2'd1,
      KIND_END   = 2'd2
   } kind_type;

   // Field widths fixed by the channel formats
   localparam int KIND_W      = 2;
   localparam int IN_COORD_W  = 25;
   localparam int OUT_COUNT_W = 16;
   localparam int FLAG_W      = 6;
   localparam logic [OUT_COUNT_W-1:0] OUT_COUNT_CAP = 16'hFFFF;
   localparam logic [FLAG_W-1:0]      FLAGS_ALL     = 6'h3F;

   // Direction flag positions
   localparam int FLAG_Z_BELOW = 0;
   localparam int FLAG_Z_ABOVE = 1;
   localparam int FLAG_Y_BELOW = 2;
   localparam int FLAG_Y_ABOVE = 3;
   localparam int FLAG_X_BELOW = 4;
   localparam int FLAG_X_ABOVE = 5;

   // Radius register; any offset of 2^NEAR_BITS or more squares past the largest radius
   localparam int R2_W      = 27;
   localparam logic [R2_W-1:0] R2_RESET = 27'd1960000;
   localparam int NEAR_BITS = 14;
   localparam int SQ_W      = 2 * NEAR_BITS;
   localparam int SUM_W     = SQ_W + 1;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_SQUARED = 1'd0;

endpackage

`default_nettype wire

/* rtl/bwct_if.sv */
// Valid/ready channel interfaces for the request and response streams.
`default_nettype none

interface bwct_req_if
   import bwct_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic [KIND_W-1:0]            kind;
   logic signed [IN_COORD_W-1:0] pos_x;
   logic signed [IN_COORD_W-1:0] pos_y;
   logic signed [IN_COORD_W-1:0] pos_z;

   modport source (output valid, kind, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, kind, pos_x, pos_y, pos_z, output ready);
endinterface

interface bwct_rsp_if
   import bwct_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   is_buried;
   logic [OUT_COUNT_W-1:0] buried_count;
   logic [FLAG_W-1:0]      direction_flags;

   modport source (output valid, is_buried, buried_count, direction_flags, input ready);
   modport sink   (input valid, is_buried, buried_count, direction_flags, output ready);
endinterface

`default_nettype wire

/* rtl/buried_water_cylinder_test.sv */
// Top level of the buried-water cylinder test.
// Stream a start item with the water position, then its atoms, then an end item; the end
// item returns whether atoms were found on all six sides (inside the axis cylinders of
// radius sqrt(radius_squared)) together with the running count of buried waters. One item
// is taken every cycle unless stalled: each item is registered on acceptance and evaluated
// from that input register by a single pass of squares and compares; the response of an
// end item is held in the response register. The only stall comes from the response
// register: an end item waits while a previous response is still held by the consumer.
`default_nettype none

module buried_water_cylinder_test
   import bwct_pkg::*;
#(
   parameter int COORD_BITS = 24,
   parameter int COUNT_BITS = 16
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   bwct_req_if.sink                   req_chan,
   bwct_rsp_if.source                 rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int WATER_W = COORD_BITS + 1;
   localparam int WIDE_W  = (COUNT_BITS > OUT_COUNT_W) ? COUNT_BITS : OUT_COUNT_W;

   logic [R2_W-1:0] radius_sq;

   // Input register
   logic                         in_vld_ff, in_vld_in;
   kind_type                     in_kind_ff;
   logic signed [IN_COORD_W-1:0] in_x_ff, in_y_ff, in_z_ff;
   logic                         req_take;
   logic                         consume;

   // Water state
   logic signed [WATER_W-1:0] water_x_ff, water_x_in;
   logic signed [WATER_W-1:0] water_y_ff, water_y_in;
   logic signed [WATER_W-1:0] water_z_ff, water_z_in;
   logic [FLAG_W-1:0]         flags_ff, flags_in;
   logic [COUNT_BITS-1:0]     total_ff, total_in;
   logic [FLAG_W-1:0]         hit;
   logic                      buried;
   logic [WIDE_W-1:0]         total_wide;

   // Response register
   logic                   out_vld_ff, out_vld_in;
   logic                   out_buried_ff;
   logic [OUT_COUNT_W-1:0] out_count_ff;
   logic [FLAG_W-1:0]      out_flags_ff;
   logic                   out_load;

   bwct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (csr_psel),
      .penable   (csr_penable),
      .pwrite    (csr_pwrite),
      .paddr     (csr_paddr),
      .pwdata    (csr_pwdata),
      .prdata    (csr_prdata),
      .pready    (csr_pready),
      .radius_sq (radius_sq)
   );

   bwct_atom_test #(
      .WATER_W (WATER_W)
   ) u_atom_test (
      .water_x   (water_x_ff),
      .water_y   (water_y_ff),
      .water_z   (water_z_ff),
      .atom_x    (in_x_ff),
      .atom_y    (in_y_ff),
      .atom_z    (in_z_ff),
      .radius_sq (radius_sq),
      .hit       (hit)
   );

   // Handshake: the registered item is consumed unless an end item finds the
   // response register still occupied
   assign consume  = in_vld_ff && ((in_kind_ff != KIND_END) || !out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !in_vld_ff || consume;
   assign req_take = req_chan.valid && req_chan.ready;
   assign out_load = consume && (in_kind_ff == KIND_END);

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_take) begin
         in_vld_in = 1'b1;
      end else if (consume) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_vld_in = 1'b0;
      end
   end

   assign buried = (flags_ff == FLAGS_ALL);

   // Water state update for the item being consumed
   always_comb begin
      water_x_in = water_x_ff;
      water_y_in = water_y_ff;
      water_z_in = water_z_ff;
      flags_in   = flags_ff;
      total_in   = total_ff;
      if (consume) begin
         unique case (in_kind_ff)
            KIND_START: begin
               water_x_in = WATER_W'(in_x_ff);
               water_y_in = WATER_W'(in_y_ff);
               water_z_in = WATER_W'(in_z_ff);
               flags_in   = '0;
            end
            KIND_ATOM: begin
               flags_in = flags_ff | hit;
            end
            KIND_END: begin
               if (buried && (total_ff != '1)) begin
                  total_in = total_ff + 1'b1;
               end
            end
            default: begin
               // unused kind code: no effect
            end
         endcase
      end
   end

   assign total_wide = WIDE_W'(total_in);

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         water_x_ff <= '0;
         water_y_ff <= '0;
         water_z_ff <= '0;
         flags_ff   <= '0;
         total_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         water_x_ff <= water_x_in;
         water_y_ff <= water_y_in;
         water_z_ff <= water_z_in;
         flags_ff   <= flags_in;
         total_ff   <= total_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_kind_ff <= kind_type'(req_chan.kind);
         in_x_ff    <= req_chan.pos_x;
         in_y_ff    <= req_chan.pos_y;
         in_z_ff    <= req_chan.pos_z;
      end
      if (out_load) begin
         out_buried_ff <= buried;
         out_flags_ff  <= flags_ff;
         out_count_ff  <= (total_wide > WIDE_W'(OUT_COUNT_CAP)) ? OUT_COUNT_CAP
                                                                 : total_wide[OUT_COUNT_W-1:0];
      end
   end

   assign rsp_chan.valid           = out_vld_ff;
   assign rsp_chan.is_buried       = out_buried_ff;
   assign rsp_chan.buried_count    = out_count_ff;
   assign rsp_chan.direction_flags = out_flags_ff;

endmodule

`default_nettype wire

/* rtl/bwct_csr.sv */
// APB-style register port holding the cylinder radius squared.
`default_nettype none

module bwct_csr
   import bwct_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output logic      [R2_W-1:0]       radius_sq
);

   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_radius;
   logic [R2_W-1:0]      radius_ff;
   logic [R2_W-1:0]      radius_in;

   // Word index; low byte-offset bits are ignored
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign pready    = 1'b1;
   assign wr_radius = psel && penable && pwrite && (reg_idx == REG_RADIUS_SQUARED);

   // Radius register next value
   always_comb begin
      radius_in = radius_ff;
      if (wr_radius) begin
         radius_in = pwdata[R2_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= R2_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      if (reg_idx == REG_RADIUS_SQUARED) begin
         prdata = CSR_DATA_W'(radius_ff);
      end
   end

   assign radius_sq = radius_ff;

endmodule

`default_nettype wire

/* rtl/bwct_atom_test.sv */
// Tests one atom against the three axis cylinders around the stored water.
`default_nettype none

module bwct_atom_test
   import bwct_pkg::*;
#(
   parameter int WATER_W = 25
)(
   input  wire logic signed [WATER_W-1:0]    water_x,
   input  wire logic signed [WATER_W-1:0]    water_y,
   input  wire logic signed [WATER_W-1:0]    water_z,
   input  wire logic signed [IN_COORD_W-1:0] atom_x,
   input  wire logic signed [IN_COORD_W-1:0] atom_y,
   input  wire logic signed [IN_COORD_W-1:0] atom_z,
   input  wire logic        [R2_W-1:0]       radius_sq,
   output logic             [FLAG_W-1:0]     hit
);

   // One bit wider than the wider operand, so the difference never overflows
   localparam int DW = ((WATER_W > IN_COORD_W) ? WATER_W : IN_COORD_W) + 1;

   logic signed [DW-1:0] dx, dy, dz;
   logic [DW-1:0]        mx, my, mz;
   logic                 far_x, far_y, far_z;
   logic [SQ_W-1:0]      sqx, sqy, sqz;
   logic [SUM_W-1:0]     sum_xy, sum_xz, sum_zy;
   logic [SUM_W-1:0]     r2_ext;
   logic                 in_z, in_y, in_x;

   // Water minus atom
   assign dx = DW'(water_x) - DW'(atom_x);
   assign dy = DW'(water_y) - DW'(atom_y);
   assign dz = DW'(water_z) - DW'(atom_z);

   // Magnitudes
   assign mx = dx[DW-1] ? (~dx + 1'b1) : dx;
   assign my = dy[DW-1] ? (~dy + 1'b1) : dy;
   assign mz = dz[DW-1] ? (~dz + 1'b1) : dz;

   // Far offsets always fall outside any programmable radius
   assign far_x = |mx[DW-1:NEAR_BITS];
   assign far_y = |my[DW-1:NEAR_BITS];
   assign far_z = |mz[DW-1:NEAR_BITS];

   // Squares of the near part
   assign sqx = mx[NEAR_BITS-1:0] * mx[NEAR_BITS-1:0];
   assign sqy = my[NEAR_BITS-1:0] * my[NEAR_BITS-1:0];
   assign sqz = mz[NEAR_BITS-1:0] * mz[NEAR_BITS-1:0];

   assign sum_xy = {1'b0, sqx} + {1'b0, sqy};
   assign sum_xz = {1'b0, sqx} + {1'b0, sqz};
   assign sum_zy = {1'b0, sqz} + {1'b0, sqy};
   assign r2_ext = SUM_W'(radius_sq);

   // Inside tests, strictly less than radius squared
   assign in_z = !far_x && !far_y && (sum_xy < r2_ext);
   assign in_y = !far_x && !far_z && (sum_xz < r2_ext);
   assign in_x = !far_z && !far_y && (sum_zy < r2_ext);

   // Side of the water; a level coordinate sets neither side
   always_comb begin
      hit               = '0;
      hit[FLAG_Z_BELOW] = in_z && !dz[DW-1] && (dz != '0);
      hit[FLAG_Z_ABOVE] = in_z && dz[DW-1];
      hit[FLAG_Y_BELOW] = in_y && !dy[DW-1] && (dy != '0);
      hit[FLAG_Y_ABOVE] = in_y && dy[DW-1];
      hit[FLAG_X_BELOW] = in_x && !dx[DW-1] && (dx != '0);
      hit[FLAG_X_ABOVE] = in_x && dx[DW-1];
   end

endmodule

`default_nettype wire

/* rtl/bwct_checker.sv */
// Port-level checker for the buried-water cylinder test, bound to the top level.
`default_nettype none

module bwct_checker
   import bwct_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic                   rsp_is_buried,
   input wire logic [OUT_COUNT_W-1:0] rsp_buried_count,
   input wire logic [FLAG_W-1:0]      rsp_direction_flags,
   input wire logic                   csr_pready
);

   // A stalled response stays valid
   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid) && !$past(rsp_ready)) |-> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its payload
   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid) && !$past(rsp_ready)) |->
      ($stable(rsp_is_buried) && $stable(rsp_buried_count) && $stable(rsp_direction_flags)))
      else $error("response payload changed while stalled");

   // Buried exactly when all six sides are flagged
   a_buried_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_buried == (rsp_direction_flags == FLAGS_ALL)))
      else $error("is_buried disagrees with direction flags");

   // A buried water is always counted
   a_buried_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_buried) |-> (rsp_buried_count != '0))
      else $error("buried water reported with zero count");

   // Register port never waits
   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready low");

endmodule

bind buried_water_cylinder_test bwct_checker u_bwct_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_is_buried       (rsp_chan.is_buried),
   .rsp_buried_count    (rsp_chan.buried_count),
   .rsp_direction_flags (rsp_chan.direction_flags),
   .csr_pready          (csr_pready)
);

`default_nettype wire

/* dv/buried_water_cylinder_test_tb.sv */
// Testbench for the buried-water cylinder test: directed table, then checked random scans.
module buried_water_cylinder_test_tb;
   import bwct_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int DRAIN_CYCLES    = 6;    // response passes the input and response registers after its end item
   localparam int PHASE_ITEMS     = 240;
   localparam int PHASES          = 7;
   localparam int SQUEEZE_PHASE   = 2;
   localparam int QUIET_PHASE     = 3;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int MAX_REPORTS     = 40;
   localparam int COORD_MAX       = 9999999;
   localparam int TALLY_CAP       = 65535;  // 2^COUNT_BITS - 1
   localparam longint DIFF_CLAMP  = 64'sd134217728;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd3;

   typedef struct packed {
      logic                   is_buried;
      logic [OUT_COUNT_W-1:0] buried_count;
      logic [FLAG_W-1:0]      direction_flags;
   } verdict_type;

   typedef struct {
      logic [KIND_W-1:0] kind;
      int                x;
      int                y;
      int                z;
      bit                typed;
      verdict_type       verdict;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bwct_req_if req_bus ();
   bwct_rsp_if rsp_bus ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Model of the block
   logic [R2_W-1:0]   radius_sq;
   longint            site_x;
   longint            site_y;
   longint            site_z;
   logic [FLAG_W-1:0] sides_seen;
   int                buried_tally;

   verdict_type pending_verdicts [$];
   int          mismatches = 0;
   int          cycles = 0;
   bit          req_idle_on;
   bit          rsp_idle_on;
   bit          hold_off_request = 1'b0;
   int          gen_x;
   int          gen_y;
   int          gen_z;

   logic [CSR_DATA_W-1:0] phase_radius [PHASES] =
      '{32'd1, 32'd2, 32'd250000, 32'hFFFF_FFFF, 32'd0, 32'd100000000, 32'd1960000};
   int phase_spread [PHASES] = '{2, 3, 600, 14000, 500, 12000, 1700};

   // Directed table; typed verdicts are the obvious ones, the rest come from the model
   stim_row_type directed_rows [25] = '{
      '{KIND_END,     0,         0,         0,         1'b1, {1'b0, 16'd0, 6'h00}},
      '{KIND_ATOM,    0,         0,         1000,      1'b0, '0},
      '{KIND_END,     0,         0,         0,         1'b1, {1'b0, 16'd0, 6'h02}},
      '{KIND_START,   9999999,   -9999999,  0,         1'b0, '0},
      '{KIND_ATOM,    9999999,   -9999999,  1,         1'b0, '0},
      '{KIND_ATOM,    9999999,   -9999999,  -1,        1'b0, '0},
      '{KIND_ATOM,    9999999,   -9998600,  0,         1'b0, '0},
      '{KIND_ATOM,    9999999,   -10001000, 0,         1'b0, '0},
      '{KIND_ATOM,    9998000,   -9999999,  0,         1'b0, '0},
      '{KIND_ATOM,    10000500,  -9999999,  0,         1'b0, '0},
      '{KIND_END,     0,         0,         0,         1'b1, {1'b1, 16'd1, 6'h3F}},
      '{KIND_IGNORED, 1234567,   -7654321,  42,        1'b0, '0},
      '{KIND_END,     0,         0,         0,         1'b1, {1'b1, 16'd2, 6'h3F}},
      '{KIND_START,   -9999999,  9999999,   -9999999,  1'b0, '0},
      '{KIND_ATOM,    9999999,   -9999999,  9999999,   1'b0, '0},
      '{KIND_ATOM,    -9999999,  9999999,   -9999999,  1'b0, '0},
      '{KIND_ATOM,    -16777216, 16777215,  -16777216, 1'b0, '0},
      '{KIND_ATOM,    16777215,  -16777216, 16777215,  1'b0, '0},
      '{KIND_END,     0,         0,         0,         1'b1, {1'b0, 16'd2, 6'h00}},
      '{KIND_START,   0,         0,         0,         1'b0, '0},
      '{KIND_ATOM,    1400,      0,         5,         1'b0, '0},
      '{KIND_ATOM,    0,         1399,      -5,        1'b0, '0},
      '{KIND_END,     0,         0,         0,         1'b1, {1'b0, 16'd2, 6'h29}},
      '{KIND_START,   16777215,  -16777216, -1,        1'b0, '0},
      '{KIND_END,     0,         0,         0,         1'b1, {1'b0, 16'd2, 6'h00}}
   };

   buried_water_cylinder_test u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #CLOCK_HALF clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic note_mismatch(input string what, input longint want, input longint got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
   endtask

   // Squared offset, clamped in magnitude first
   function automatic longint offset_square(input longint d);
      if (d < 0)
         d = -d;
      if (d > DIFF_CLAMP)
         d = DIFF_CLAMP;
      return d * d;
   endfunction

   // Side flag of one cylinder: strictly inside, and not level with the water
   function automatic logic [FLAG_W-1:0] side_hit(input longint w, input longint a,
                                                 input longint d2, input int below,
                                                 input int above);
      logic [FLAG_W-1:0] hit;
      hit = '0;
      if (d2 < longint'(radius_sq)) begin
         if (a < w)
            hit[below] = 1'b1;
         else if (a > w)
            hit[above] = 1'b1;
      end
      return hit;
   endfunction

   function automatic void advance_model(input logic [KIND_W-1:0] kind,
                                         input logic signed [IN_COORD_W-1:0] x,
                                         input logic signed [IN_COORD_W-1:0] y,
                                         input logic signed [IN_COORD_W-1:0] z,
                                         output bit made, output verdict_type v);
      longint ax;
      longint ay;
      longint az;
      longint dx2;
      longint dy2;
      longint dz2;
      bit     buried;
      made = 1'b0;
      v    = '0;
      ax   = x;
      ay   = y;
      az   = z;
      case (kind)
         KIND_START: begin
            site_x     = ax;
            site_y     = ay;
            site_z     = az;
            sides_seen = '0;
         end
         KIND_ATOM: begin
            dx2 = offset_square(site_x - ax);
            dy2 = offset_square(site_y - ay);
            dz2 = offset_square(site_z - az);
            sides_seen |= side_hit(site_z, az, dx2 + dy2, FLAG_Z_BELOW, FLAG_Z_ABOVE);
            sides_seen |= side_hit(site_y, ay, dx2 + dz2, FLAG_Y_BELOW, FLAG_Y_ABOVE);
            sides_seen |= side_hit(site_x, ax, dz2 + dy2, FLAG_X_BELOW, FLAG_X_ABOVE);
         end
         KIND_END: begin
            buried = (sides_seen == FLAGS_ALL);
            if (buried && buried_tally < TALLY_CAP)
               buried_tally++;
            v.is_buried       = buried;
            v.buried_count    = (buried_tally > int'(OUT_COUNT_CAP)) ? OUT_COUNT_CAP
                                                                     : OUT_COUNT_W'(buried_tally);
            v.direction_flags = sides_seen;
            made              = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // Mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int full_field_coord();
      logic [31:0] r;
      r = $urandom;
      return int'($signed(r[IN_COORD_W-1:0]));
   endfunction

   function automatic int site_coord();
      if ($urandom_range(0, 9) == 0)
         return full_field_coord();
      return int'($urandom_range(0, 2 * COORD_MAX)) - COORD_MAX;
   endfunction

   function automatic int spread_offset(input int s);
      if ($urandom_range(0, 5) == 0)
         return 0;
      return int'($urandom_range(0, 2 * s)) - s;
   endfunction

   // One request transfer; the model runs on acceptance
   task automatic send_item(input logic [KIND_W-1:0] kind, input int x, input int y,
                            input int z, input bit typed, input verdict_type typed_verdict);
      int                           gap;
      bit                           made;
      verdict_type                  v;
      logic signed [IN_COORD_W-1:0] fx;
      logic signed [IN_COORD_W-1:0] fy;
      logic signed [IN_COORD_W-1:0] fz;
      fx  = x[IN_COORD_W-1:0];
      fy  = y[IN_COORD_W-1:0];
      fz  = z[IN_COORD_W-1:0];
      gap = req_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.pos_x <= fx;
      req_bus.pos_y <= fy;
      req_bus.pos_z <= fz;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      advance_model(kind, fx, fy, fz, made, v);
      if (made)
         pending_verdicts.push_back(typed ? typed_verdict : v);
   endtask

   // Atom near the current water, pushed out along one axis
   task automatic send_near_atom(input int s);
      int o [3];
      int axis;
      axis = $urandom_range(0, 2);
      for (int i = 0; i < 3; i++)
         o[i] = spread_offset(s);
      o[axis] = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, 3 * s));
      send_item(KIND_ATOM, gen_x + o[0], gen_y + o[1], gen_z + o[2], 1'b0, '0);
   endtask

   task automatic csr_transfer(input bit wr, input logic [CSR_DATA_W-1:0] wdata,
                               output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {REG_RADIUS_SQUARED, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Stop offering, let every verdict arrive, then let the pipeline settle
   task automatic wait_quiet();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Random water scans: mostly start/atoms/end, plus ignored items and stray atoms or ends
   task automatic run_phase(input int spread, input bit squeeze);
      int sent;
      int pick;
      int atoms;
      bit squeezed;
      sent     = 0;
      squeezed = 1'b0;
      while (sent < PHASE_ITEMS) begin
         if (squeeze && !squeezed && sent >= PHASE_ITEMS / 2) begin
            hold_off_request = 1'b1;
            squeezed         = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 82) begin
            gen_x = site_coord();
            gen_y = site_coord();
            gen_z = site_coord();
            send_item(KIND_START, gen_x, gen_y, gen_z, 1'b0, '0);
            atoms = $urandom_range(1, 14);
            repeat (atoms) begin
               if ($urandom_range(0, 6) == 0)
                  send_item(KIND_ATOM, full_field_coord(), full_field_coord(),
                            full_field_coord(), 1'b0, '0);
               else
                  send_near_atom(spread);
            end
            sent += atoms + 1;
            // now and then the end item is dropped and the next start takes over
            if ($urandom_range(0, 9) != 0) begin
               send_item(KIND_END, site_coord(), site_coord(), site_coord(), 1'b0, '0);
               sent++;
            end
         end else if (pick < 90) begin
            send_item(KIND_IGNORED, full_field_coord(), full_field_coord(),
                      full_field_coord(), 1'b0, '0);
         end else if (pick < 95) begin
            send_item(KIND_END, site_coord(), site_coord(), site_coord(), 1'b0, '0);
            sent++;
         end else begin
            send_near_atom(spread);
            sent++;
         end
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin : drain_responses
      int gap;
      rsp_bus.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_off_request) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            if (gap > 0) begin
               @(negedge clock);
               rsp_bus.ready <= 1'b0;
               repeat (gap - 1) @(negedge clock);
            end
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare each response transfer with the oldest pending verdict
   always @(posedge clock) begin : check_verdicts
      verdict_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: response with none pending: expected none, got %0d/%0d/%0h",
                        $time, rsp_bus.is_buried, rsp_bus.buried_count,
                        rsp_bus.direction_flags);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_bus.is_buried !== want.is_buried)
               note_mismatch("is_buried", want.is_buried, rsp_bus.is_buried);
            if (rsp_bus.buried_count !== want.buried_count)
               note_mismatch("buried_count", want.buried_count, rsp_bus.buried_count);
            if (rsp_bus.direction_flags !== want.direction_flags)
               note_mismatch("direction_flags", want.direction_flags, rsp_bus.direction_flags);
         end
      end
   end

   initial begin : sequencer
      logic [CSR_DATA_W-1:0] readback;
      req_bus.valid <= 1'b0;
      req_bus.kind  <= KIND_START;
      req_bus.pos_x <= '0;
      req_bus.pos_y <= '0;
      req_bus.pos_z <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      radius_sq     = R2_RESET;
      site_x        = 0;
      site_y        = 0;
      site_z        = 0;
      sides_seen    = '0;
      buried_tally  = 0;
      gen_x         = 0;
      gen_y         = 0;
      gen_z         = 0;
      req_idle_on   = 1'b1;
      rsp_idle_on   = 1'b1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part runs with the reset radius
      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].x, directed_rows[i].y,
                   directed_rows[i].z, directed_rows[i].typed, directed_rows[i].verdict);
      wait_quiet();

      // Random part, one radius per phase
      for (int p = 0; p < PHASES; p++) begin
         csr_transfer(1'b1, phase_radius[p], readback);
         radius_sq = phase_radius[p][R2_W-1:0];
         csr_transfer(1'b0, '0, readback);
         if (readback !== CSR_DATA_W'(radius_sq))
            note_mismatch("radius_squared readback", radius_sq, readback);
         req_idle_on = (p != QUIET_PHASE);
         rsp_idle_on = (p != QUIET_PHASE);
         run_phase(phase_spread[p], p == SQUEEZE_PHASE);
         wait_quiet();
      end

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
